/* hw/rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character lookup for the base64 stream
// decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    // field widths
    localparam int CHAR_W       = 8;
    localparam int CAP_W        = 16;
    localparam int BYTE_COUNT_W = 16;
    localparam int KIND_W       = 2;
    localparam int COUNT_WIDTH  = 16;

    // capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = '1;

    // job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // work handed from the front to the back for one item
    typedef struct packed {
        logic                   err;
        logic                   done;
        logic [1:0]             nbytes;
        logic [7:0]             byte0;
        logic [7:0]             byte1;
        logic [7:0]             byte2;
        logic [COUNT_WIDTH-1:0] count;
    } job_t;

    // alphabet lookup: bit 6 set when the character is not in the alphabet
    function automatic logic [6:0] sextet_of(input logic [CHAR_W-1:0] ch);
        logic [6:0] v;
        v = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            v = {1'b0, 6'(ch - 8'h41)};
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            v = {1'b0, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            v = {1'b0, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2B) begin
            v = {1'b0, 6'd62};
        end else if (ch == 8'h2F) begin
            v = {1'b0, 6'd63};
        end
        return v;
    endfunction

endpackage

/* hw/rtl/b64d_intf.sv */
// ----------------------------------------------------------------------------
// b64d channel interfaces
// Valid/ready channels for text characters, decoded results and the
// capacity register write.
// ----------------------------------------------------------------------------

// text character channel
interface b64d_text_if;
    import b64d_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// decoded result channel
interface b64d_result_if;
    import b64d_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic [7:0]              data_byte;
    logic [BYTE_COUNT_W-1:0] byte_count;
    logic                    last_of_run;

    modport source (output valid, output kind, output data_byte, output byte_count,
                    output last_of_run, input ready);
    modport sink   (input valid, input kind, input data_byte, input byte_count,
                    input last_of_run, output ready);
endinterface

// capacity write channel
interface b64d_cfg_if;
    import b64d_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

/* hw/rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, gathers groups of four, checks alphabet and capacity
// and pushes one job per item that causes results.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic               clk,
    input  logic               rst_n,
    b64d_text_if.sink          text_in,
    b64d_cfg_if.sink           cfg,
    input  logic               queue_full,
    output logic               push,
    output b64d_pkg::job_t     push_job
);
    import b64d_pkg::*;

    localparam int SUM_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 2;

    logic [CAP_W-1:0]       capacity_reg;
    logic [1:0]             pos_reg,    pos_next;
    logic [5:0]             first_reg,  first_next;
    logic [5:0]             second_reg, second_next;
    logic [6:0]             third_reg,  third_next;
    logic                   head_bad_reg, head_bad_next;
    logic [COUNT_WIDTH-1:0] count_reg,  count_next;
    logic                   failed_reg, failed_next;

    logic                   accept;
    logic                   last;
    logic [6:0]             v;
    logic [SUM_W-1:0]       need;
    logic [SUM_W-1:0]       cap_ext;
    logic [SUM_W-1:0]       max_ext;
    logic [SUM_W-1:0]       limit;
    logic                   over;
    logic [1:0]             nbytes;
    job_t                   job;

    assign text_in.ready = !queue_full;
    assign cfg.ready     = 1'b1;
    assign accept        = text_in.valid && text_in.ready;
    assign last          = text_in.end_of_text;
    assign v             = sextet_of(text_in.text_char);

    // capacity check, limit is the smaller of capacity and the count range
    assign need    = SUM_W'(count_reg) + SUM_W'(3);
    assign cap_ext = SUM_W'(capacity_reg);
    assign max_ext = SUM_W'({COUNT_WIDTH{1'b1}});
    assign limit   = (cap_ext < max_ext) ? cap_ext : max_ext;
    assign over    = need > limit;

    // bytes produced by a complete group
    assign nbytes = third_reg[6] ? 2'd1 : (v[6] ? 2'd2 : 2'd3);

    // group assembly and job build
    always_comb
    begin
        pos_next      = pos_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        third_next    = third_reg;
        head_bad_next = head_bad_reg;
        count_next    = count_reg;
        failed_next   = failed_reg;
        push          = 1'b0;
        job.err       = 1'b0;
        job.done      = last;
        job.nbytes    = 2'd0;
        job.byte0     = {first_reg, second_reg[5:4]};
        job.byte1     = {second_reg[3:0], third_reg[5:2]};
        job.byte2     = {third_reg[1:0], v[5:0]};
        job.count     = count_reg;

        if (accept) begin
            if (failed_reg) begin
                // dropping until end of text
            end else begin
                case (pos_reg)
                    2'd0:
                    begin
                        first_next    = v[5:0];
                        head_bad_next = v[6];
                        pos_next      = 2'd1;
                        push          = last;
                    end
                    2'd1:
                    begin
                        second_next   = v[5:0];
                        head_bad_next = head_bad_reg || v[6];
                        pos_next      = 2'd2;
                        push          = last;
                    end
                    2'd2:
                    begin
                        third_next = v;
                        pos_next   = 2'd3;
                        push       = last;
                    end
                    default:
                    begin
                        pos_next = 2'd0;
                        push     = 1'b1;
                        if (head_bad_reg || over) begin
                            job.err     = 1'b1;
                            job.done    = 1'b0;
                            failed_next = 1'b1;
                        end else begin
                            job.nbytes = nbytes;
                            count_next = count_reg + COUNT_WIDTH'(nbytes);
                            job.count  = count_next;
                        end
                    end
                endcase
            end

            // end of text returns the text state to reset
            if (last) begin
                pos_next      = 2'd0;
                first_next    = '0;
                second_next   = '0;
                third_next    = '0;
                head_bad_next = 1'b0;
                count_next    = '0;
                failed_next   = 1'b0;
            end
        end
    end

    assign push_job = job;

    // text state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= CAP_RESET;
            pos_reg      <= 2'd0;
            first_reg    <= '0;
            second_reg   <= '0;
            third_reg    <= '0;
            head_bad_reg <= 1'b0;
            count_reg    <= '0;
            failed_reg   <= 1'b0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                capacity_reg <= cfg.capacity;
            end
            pos_reg      <= pos_next;
            first_reg    <= first_next;
            second_reg   <= second_next;
            third_reg    <= third_next;
            head_bad_reg <= head_bad_next;
            count_reg    <= count_next;
            failed_reg   <= failed_next;
        end
    end

endmodule

/* hw/rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  b64d_pkg::job_t     push_job,
    input  logic               pop,
    output b64d_pkg::job_t     head_job,
    output logic               full,
    output logic               empty
);
    import b64d_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = cnt_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hw/rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and sends their results one per cycle, while the
// output is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic               clk,
    input  logic               rst_n,
    input  b64d_pkg::job_t     head_job,
    input  logic               empty,
    output logic               pop,
    b64d_result_if.source      result_out
);
    import b64d_pkg::*;

    logic [1:0]              idx_reg,   idx_next;
    logic                    ovalid_reg, ovalid_next;
    kind_t                   kind_reg,  kind_next;
    logic [7:0]              byte_reg,  byte_next;
    logic [BYTE_COUNT_W-1:0] bcount_reg, bcount_next;
    logic                    last_reg,  last_next;

    logic                    advance;
    logic                    emit;
    logic [2:0]              total;
    logic                    is_last;

    assign advance = !ovalid_reg || result_out.ready;
    assign emit    = advance && !empty;
    assign total   = head_job.err ? 3'd1 : ({1'b0, head_job.nbytes} + {2'b00, head_job.done});
    assign is_last = {1'b0, idx_reg} == (total - 3'd1);
    assign pop     = emit && is_last;

    // result selection for the current position within the job
    always_comb
    begin
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        bcount_next = bcount_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        ovalid_next = ovalid_reg && !result_out.ready;
        if (emit) begin
            ovalid_next = 1'b1;
            last_next   = is_last;
            idx_next    = is_last ? 2'd0 : idx_reg + 2'd1;
            byte_next   = '0;
            bcount_next = '0;
            if (head_job.err) begin
                kind_next = KIND_ERROR;
            end else if (idx_reg < head_job.nbytes) begin
                kind_next = KIND_BYTE;
                case (idx_reg)
                    2'd0:    byte_next = head_job.byte0;
                    2'd1:    byte_next = head_job.byte1;
                    default: byte_next = head_job.byte2;
                endcase
            end else begin
                kind_next   = KIND_DONE;
                bcount_next = BYTE_COUNT_W'(head_job.count);
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end else begin
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // output payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        bcount_reg <= bcount_next;
        last_reg   <= last_next;
    end

    assign result_out.valid       = ovalid_reg;
    assign result_out.kind        = kind_reg;
    assign result_out.data_byte   = byte_reg;
    assign result_out.byte_count  = bcount_reg;
    assign result_out.last_of_run = last_reg;

endmodule

/* hw/rtl/base64_stream_decoder_core.sv */
// Path: a taken item's job is written into the job queue, and the back then loads
// its results into the output register when the back is idle.
// Throughput: one character per cycle unless the queue is full; one result per cycle
// unless the output stalls, up to four per item, absorbed by the four-entry job queue.
// Reset: asynchronous, active low; clears the group, the byte count, the error flag
// and the queue, and sets capacity to 65535. No clearing pass is needed.
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: characters in, decoded bytes, end count or
// error out.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core (
    input  logic           clk,
    input  logic           rst_n,
    b64d_text_if.sink      text_in,
    b64d_cfg_if.sink       cfg,
    b64d_result_if.source  result_out
);
    import b64d_pkg::*;

    logic push;
    job_t push_job;
    logic pop;
    job_t head_job;
    logic full;
    logic empty;

    // classify characters and build jobs
    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .cfg        (cfg),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    // job queue
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    // send results
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .empty      (empty),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

/* test/base64_stream_decoder_core_tb.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder_core_tb
// Self-checking bench for the streaming base64 decoder. Texts are driven one
// character per item with random gaps while the result side stalls at random.
// A scoreboard class predicts every decoded byte, end count and error from
// its own copy of the group state and the capacity setting, and matches each
// result against the oldest prediction. Capacity is rewritten between phases
// while the block is idle, from zero up to full scale.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core_tb;
    import b64d_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int IDLE_SLACK       = 12;
    localparam int DRAIN_CYCLES     = 20;
    localparam int RANDOM_PER_PHASE = 10;
    localparam int NUM_PHASES       = 8;

    // one decoded result as seen on the output channel
    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [7:0]              data_byte;
        logic [BYTE_COUNT_W-1:0] byte_count;
        logic                    last_of_run;
    } b64_result_t;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    // ------------------------------------------------------------------------
    // decoder predictor and result matcher
    // ------------------------------------------------------------------------
    class b64_scoreboard;
        logic [CAP_W-1:0]        capacity;
        logic [1:0]              slot;
        logic [5:0]              sx_a;
        logic [5:0]              sx_b;
        logic [6:0]              sx_c;
        logic                    head_bad;
        logic [COUNT_WIDTH-1:0]  decoded;
        logic                    failed;
        b64_result_t             expected_q[$];
        b64_result_t             held;
        bit                      have_held;
        int                      errors;

        function new();
            capacity  = CAP_RESET;
            errors    = 0;
            have_held = 0;
            clear_text();
        endfunction

        function void clear_text();
            slot     = 2'd0;
            sx_a     = '0;
            sx_b     = '0;
            sx_c     = '0;
            head_bad = 1'b0;
            decoded  = '0;
            failed   = 1'b0;
        endfunction

        // six-bit value of a character, bit 6 flags a non-alphabet character
        function logic [6:0] lookup(logic [7:0] ch);
            logic [6:0] v;
            v = 7'h40;
            if (ch >= "A" && ch <= "Z")
                v = {1'b0, 6'(ch - "A")};
            else if (ch >= "a" && ch <= "z")
                v = {1'b0, 6'(ch - "a" + 8'd26)};
            else if (ch >= "0" && ch <= "9")
                v = {1'b0, 6'(ch - "0" + 8'd52)};
            else if (ch == "+")
                v = 7'd62;
            else if (ch == "/")
                v = 7'd63;
            return v;
        endfunction

        // results of one item are held back by one so the last can be flagged
        function void emit(kind_t k, logic [7:0] b, logic [COUNT_WIDTH-1:0] n);
            if (have_held)
                expected_q.push_back(held);
            held.kind        = k;
            held.data_byte   = b;
            held.byte_count  = BYTE_COUNT_W'(n);
            held.last_of_run = 1'b0;
            have_held        = 1;
        endfunction

        function void close_run();
            if (have_held)
            begin
                held.last_of_run = 1'b1;
                expected_q.push_back(held);
                have_held = 0;
            end
        endfunction

        // predict the results of one accepted item; returns 0 when it is dropped
        function bit note_text(logic [7:0] ch, logic eot);
            logic [6:0] v;
            v = lookup(ch);
            if (failed)
            begin
                if (eot)
                    clear_text();
                return 0;
            end
            case (slot)
                2'd0:
                begin
                    sx_a     = v[5:0];
                    head_bad = v[6];
                    slot     = 2'd1;
                end
                2'd1:
                begin
                    sx_b     = v[5:0];
                    head_bad = head_bad | v[6];
                    slot     = 2'd2;
                end
                2'd2:
                begin
                    sx_c = v;
                    slot = 2'd3;
                end
                default:
                begin
                    slot = 2'd0;
                    // room for three bytes is asked whatever the padding
                    if (head_bad || ({1'b0, decoded} + 17'd3 > {1'b0, capacity}))
                    begin
                        emit(KIND_ERROR, 8'h00, '0);
                        failed = 1'b1;
                    end
                    else
                    begin
                        emit(KIND_BYTE, {sx_a, sx_b[5:4]}, '0);
                        decoded = decoded + 1'b1;
                        if (!sx_c[6])
                        begin
                            emit(KIND_BYTE, {sx_b[3:0], sx_c[5:2]}, '0);
                            decoded = decoded + 1'b1;
                            if (!v[6])
                            begin
                                emit(KIND_BYTE, {sx_c[1:0], v[5:0]}, '0);
                                decoded = decoded + 1'b1;
                            end
                        end
                    end
                end
            endcase
            if (eot && !failed)
                emit(KIND_DONE, 8'h00, decoded);
            if (eot)
                clear_text();
            close_run();
            return 1;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // match one accepted result against the oldest prediction
        function void check_result(b64_result_t got);
            b64_result_t exp;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result kind=%0d byte=%02h count=%0d last=%0b",
                         $time, got.kind, got.data_byte, got.byte_count, got.last_of_run);
                return;
            end
            exp = expected_q.pop_front();
            if (got.kind !== exp.kind || got.data_byte !== exp.data_byte ||
                got.byte_count !== exp.byte_count || got.last_of_run !== exp.last_of_run)
            begin
                errors++;
                $display("%0t: mismatch kind exp %0d act %0d, byte exp %02h act %02h",
                         $time, exp.kind, got.kind, exp.data_byte, got.data_byte);
                $display("%0t:   count exp %0d act %0d, last exp %0b act %0b",
                         $time, exp.byte_count, got.byte_count,
                         exp.last_of_run, got.last_of_run);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    b64d_text_if   text_if();
    b64d_cfg_if    cfg_if();
    b64d_result_if res_if();

    b64_scoreboard sb;
    int            cycles     = 0;
    int            live_items = 0;
    int            stall_left = 0;
    int            calm_left  = 0;

    base64_stream_decoder_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_if),
        .cfg        (cfg_if),
        .result_out (res_if)
    );

    // clock
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side back-pressure: short stalls, rare long ones, calm stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if (calm_left > 0)
                calm_left <= calm_left - 1;
            else
            begin
                case ($urandom_range(0, 99)) inside
                    [0:19]:  stall_left <= $urandom_range(1, 3);
                    [20:23]: stall_left <= $urandom_range(8, 30);
                    [24:27]: calm_left  <= $urandom_range(20, 80);
                    default: ;
                endcase
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        b64_result_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got.kind        = res_if.kind;
            got.data_byte   = res_if.data_byte;
            got.byte_count  = res_if.byte_count;
            got.last_of_run = res_if.last_of_run;
            sb.check_result(got);
        end
    end

    // sender gap length
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] alpha_char(int idx);
        if (idx < 26)
            return 8'("A" + idx);
        else if (idx < 52)
            return 8'("a" + idx - 26);
        else if (idx < 62)
            return 8'("0" + idx - 52);
        else if (idx == 62)
            return "+";
        return "/";
    endfunction

    // padding: '=' half the time, otherwise any non-alphabet byte
    function automatic logic [7:0] pad_char();
        logic [7:0] ch;
        logic [6:0] v;
        if ($urandom_range(0, 1) == 0)
            return "=";
        do
        begin
            ch = 8'($urandom_range(0, 255));
            v  = sb.lookup(ch);
        end
        while (!v[6]);
        return ch;
    endfunction

    function automatic char_q_t from_string(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
            q.push_back(s[i]);
        return q;
    endfunction

    // random text: mostly well-formed groups, some broken, some pure noise
    function automatic char_q_t random_text();
        char_q_t q;
        int      r;
        int      groups;
        int      pads;
        r = $urandom_range(0, 99);
        if (r >= 85)
        begin
            repeat ($urandom_range(1, 9))
                q.push_back(8'($urandom_range(0, 255)));
            return q;
        end
        groups = $urandom_range(1, 4);
        for (int g = 0; g < groups; g++)
        begin
            if (g == groups - 1 || $urandom_range(0, 9) == 0)
                pads = $urandom_range(0, 2);
            else
                pads = 0;
            q.push_back(alpha_char($urandom_range(0, 63)));
            q.push_back(alpha_char($urandom_range(0, 63)));
            q.push_back(pads >= 2 ? pad_char() : alpha_char($urandom_range(0, 63)));
            q.push_back(pads >= 1 ? pad_char() : alpha_char($urandom_range(0, 63)));
        end
        // trailing partial group
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
                q.push_back(alpha_char($urandom_range(0, 63)));
        // broken text: one character replaced by a random byte
        if (r >= 70)
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        return q;
    endfunction

    // one character item; returns at the falling edge after acceptance
    task automatic send_char(logic [7:0] ch, logic eot, int gap, bit drain);
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            text_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
            if (drain)
                while (sb.pending() != 0)
                    @(negedge clk);
        end
        text_if.valid       = 1'b1;
        text_if.text_char   = ch;
        text_if.end_of_text = eot;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
        if (sb.note_text(ch, eot))
            live_items++;
        @(negedge clk);
    endtask

    task automatic send_text(char_q_t chars, bit steady, int pause_at);
        for (int i = 0; i < chars.size(); i++)
            send_char(chars[i], i == chars.size() - 1, steady ? 0 : pick_gap(), i == pause_at);
    endtask

    // capacity write once the decoder has gone quiet
    task automatic write_capacity(logic [CAP_W-1:0] value);
        text_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (IDLE_SLACK) @(negedge clk);
        cfg_if.valid    = 1'b1;
        cfg_if.capacity = value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        sb.capacity = value;
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // main sequence
    initial
    begin
        char_q_t          t;
        logic [CAP_W-1:0] cap;
        int               target;
        sb                  = new();
        rst_n               = 1'b0;
        text_if.valid       = 1'b0;
        text_if.text_char   = '0;
        text_if.end_of_text = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.capacity     = '0;
        res_if.ready        = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // alphabet extremes, full capacity after reset
        send_text(from_string("AZaz09+/"), 0, -1);
        // one and two padding characters
        send_text(from_string("QUI=QQ=="), 0, -1);
        // bad first character, later items dropped up to the end
        t    = from_string("?AAAAB");
        t[0] = 8'h00;
        send_text(t, 0, -1);
        // bad second character reported on the end item
        t    = from_string("A?==");
        t[1] = 8'hFF;
        send_text(t, 0, -1);
        // partial group at the end gives only the end count
        send_text(from_string("AB"), 0, -1);
        // capacity too small for the first group
        write_capacity(16'd0);
        send_text(from_string("AAAA"), 0, -1);

        // random phases over several capacity settings
        target = live_items;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: cap = 16'd3;
                1: cap = 16'd6;
                2: cap = 16'd0;
                3: cap = 16'hFFFF;
                4: cap = CAP_W'($urandom_range(0, 65535));
                5: cap = 16'd9;
                6: cap = CAP_W'($urandom_range(0, 30));
                default: cap = 16'hFFFF;
            endcase
            write_capacity(cap);
            target += RANDOM_PER_PHASE;
            // mid-text hold-off until every result is out
            t = random_text();
            send_text(t, 0, (p == 1 || $urandom_range(0, 2) == 0) ? t.size() / 2 : -1);
            while (live_items < target)
                send_text(random_text(), $urandom_range(0, 3) == 0, -1);
        end

        // drain
        text_if.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_intf.sv
hw/rtl/b64d_front.sv
hw/rtl/b64d_queue.sv
hw/rtl/b64d_back.sv
hw/rtl/base64_stream_decoder_core.sv
test/base64_stream_decoder_core_tb.sv
